/* src/blp_pkg.sv */
// Package: shared constants, types and the step pattern decoder for the bicolor LED dimmer.
package blp_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int LEVEL_INPUTS     = 8;

    localparam int LEVEL_W    = 9;
    localparam int PERIOD_W   = 12;
    localparam int STEP_W     = 4;
    localparam int STEP_LEN_W = 16;
    localparam int STEP_CNT_W = 24;
    localparam int MASK_W     = 4;
    localparam int CHAN_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [PERIOD_W-1:0]   PERIOD_RESET  = 12'd176;
    localparam logic [LEVEL_W-1:0]    FULL_Q8       = 9'd256;
    localparam logic [5:0]            FIFTH_Q8      = 6'd51;
    localparam logic [STEP_CNT_W-1:0] STEP_CNT_MAX  = {STEP_CNT_W{1'b1}};

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEQ_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HW_PWM     = 2'd2;

    // Pattern entry codes
    typedef logic [1:0] pat_code_t;
    localparam pat_code_t PAT_OFF   = 2'd0;
    localparam pat_code_t PAT_FULL  = 2'd1;
    localparam pat_code_t PAT_FIFTH = 2'd2;

    typedef struct packed {
        logic              in_ready;
        logic              step_en;
        logic              latch_en;
        logic              mul_en;
        logic              cmp_en;
        logic              finish;
        logic [CHAN_W-1:0] chan;
    } blp_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } blp_status_t;

    // Built-in pattern: single LEDs first, then each pair as full/fifth and fifth/full.
    function automatic pat_code_t pattern_code(input logic [4:0] step, input logic [4:0] led,
                                               input logic [4:0] num_leds);
        logic [4:0] t;
        logic [4:0] p;
        begin
            pattern_code = PAT_OFF;
            t = step - num_leds;
            p = {t[4:1], 1'b0};
            if (step < num_leds)
            begin
                if (led == step)
                    pattern_code = PAT_FULL;
            end
            else if (t < num_leds)
            begin
                if (led == p)
                    pattern_code = t[0] ? PAT_FIFTH : PAT_FULL;
                else if (led == p + 5'd1)
                    pattern_code = t[0] ? PAT_FULL : PAT_FIFTH;
            end
        end
    endfunction

endpackage

/* src/blp_ifs.sv */
// Interfaces: sample input channel, result output channel and configuration write channel.
interface blp_sample_if;
    import blp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  frame_start;
    logic [STEP_LEN_W-1:0] step_len_samples;
    logic [LEVEL_W-1:0]    master_level;
    logic [LEVEL_W-1:0]    level_0;
    logic [LEVEL_W-1:0]    level_1;
    logic [LEVEL_W-1:0]    level_2;
    logic [LEVEL_W-1:0]    level_3;
    logic [LEVEL_W-1:0]    level_4;
    logic [LEVEL_W-1:0]    level_5;
    logic [LEVEL_W-1:0]    level_6;
    logic [LEVEL_W-1:0]    level_7;

    modport source (output valid, frame_start, step_len_samples, master_level,
                    level_0, level_1, level_2, level_3, level_4, level_5, level_6, level_7,
                    input ready);
    modport sink (input valid, frame_start, step_len_samples, master_level,
                  level_0, level_1, level_2, level_3, level_4, level_5, level_6, level_7,
                  output ready);
endinterface

interface blp_result_if;
    import blp_pkg::*;
    logic              valid;
    logic              ready;
    logic              soft_pwm_out;
    logic [MASK_W-1:0] pin_drive_mask;
    logic              pin_level;
    logic [STEP_W-1:0] current_step;

    modport source (output valid, soft_pwm_out, pin_drive_mask, pin_level, current_step,
                    input ready);
    modport sink (input valid, soft_pwm_out, pin_drive_mask, pin_level, current_step,
                  output ready);
endinterface

interface blp_cfg_if;
    import blp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* src/bicolor_led_tristate_pwm.sv */
// Top level: bicolor LED tri-state PWM dimmer, controller plus datapath.
//
// One transfer on the sample channel is one sample tick; each tick gives exactly one
// transfer on the result channel. The block works one tick at a time: a tick passes
// through the step and latch states, then multiply and compare per served channel, and
// waits in the done state while the result register is occupied; the single shared
// multiplier forms brightness times period for one channel in S_MUL and S_CMP compares it.
// The next tick is taken as soon as the result is loaded, even if it has not yet been
// taken downstream. Brightness is Q1.8 (256 = full). On a frame-start tick the eight
// levels are latched, from the level inputs or from the built-in 16-step pattern scaled
// by master_level; in pattern mode the step advances at a frame start once the step
// length has been counted. Channel c is driven while period_count*256 is below
// brightness*pwm_period of the served LED of its pair; pin_level names the served LED.
// The configuration channel is always ready and must only be written while idle.
module bicolor_led_tristate_pwm #(
    parameter int NUM_CHANNELS = blp_pkg::NUM_CHANNELS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    blp_sample_if.sink   sample,
    blp_result_if.source result,
    blp_cfg_if.sink      cfg
);
    import blp_pkg::*;

    blp_cmd_t    cmd;     // controller -> datapath
    blp_status_t status;  // datapath -> controller

    // sequencer FSM: step, latch, then multiply/compare per served channel
    blp_controller #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .status(status),
        .cmd   (cmd)
    );

    // all storage and arithmetic; owns the channel handshakes
    blp_datapath #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .status(status),
        .sample(sample),
        .result(result),
        .cfg   (cfg)
    );

endmodule

/* src/blp_datapath.sv */
// Datapath: config registers, sequencer state, brightness latches, shared multiplier and result register.
module blp_datapath #(
    parameter int NUM_CHANNELS = blp_pkg::NUM_CHANNELS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  blp_pkg::blp_cmd_t    cmd,
    output blp_pkg::blp_status_t status,
    blp_sample_if.sink           sample,
    blp_result_if.source         result,
    blp_cfg_if.sink              cfg
);
    import blp_pkg::*;

    localparam int NUM_LEDS  = 2 * NUM_CHANNELS;
    localparam int LED_IDX_W = $clog2(NUM_LEDS);
    localparam int PROD_W    = LEVEL_W + PERIOD_W;

    // configuration
    logic [PERIOD_W-1:0] pwm_period_reg;
    logic                seq_mode_reg;
    logic                hw_mode_reg;

    // captured sample
    logic                  frame_start_reg;
    logic [STEP_LEN_W-1:0] step_len_reg;
    logic [LEVEL_W-1:0]    master_reg;
    logic [LEVEL_W-1:0]    level_reg [LEVEL_INPUTS];
    logic [LEVEL_W-1:0]    level_in  [LEVEL_INPUTS];

    // block state
    logic [PERIOD_W-1:0]   period_count_reg;
    logic [PERIOD_W-1:0]   period_count_next;
    logic                  parity_reg;
    logic [STEP_W-1:0]     step_index_reg;
    logic [STEP_CNT_W-1:0] step_cnt_reg;
    logic [STEP_CNT_W-1:0] step_cnt_chk;
    logic                  step_adv;
    logic [LEVEL_W-1:0]    bright_reg [NUM_LEDS];

    // per-item work
    logic                 led_reg;
    logic                 soft_reg;
    logic [MASK_W-1:0]    mask_reg;
    logic [PROD_W-1:0]    product_reg;
    logic [LED_IDX_W-1:0] bright_idx;
    logic [PROD_W-1:0]    count_scaled;
    logic [LEVEL_W+5:0]   fifth_prod;
    logic [LEVEL_W-1:0]   fifth_val;
    logic                 parity_eff;

    // result register
    logic              out_valid_reg;
    logic              out_soft_reg;
    logic [MASK_W-1:0] out_mask_reg;
    logic              out_led_reg;
    logic [STEP_W-1:0] out_step_reg;

    logic accept;

    assign accept       = sample.valid && cmd.in_ready;
    assign sample.ready = cmd.in_ready;
    assign cfg.ready    = 1'b1;

    assign status.in_valid = sample.valid;
    assign status.out_free = !out_valid_reg || result.ready;

    assign level_in[0] = sample.level_0;
    assign level_in[1] = sample.level_1;
    assign level_in[2] = sample.level_2;
    assign level_in[3] = sample.level_3;
    assign level_in[4] = sample.level_4;
    assign level_in[5] = sample.level_5;
    assign level_in[6] = sample.level_6;
    assign level_in[7] = sample.level_7;

    // (51*m + 128) >> 8; full entries give m exactly
    assign fifth_prod = (LEVEL_W+6)'(master_reg) * (LEVEL_W+6)'(FIFTH_Q8) + (LEVEL_W+6)'(128);
    assign fifth_val  = LEVEL_W'(fifth_prod >> 8);

    assign step_adv     = frame_start_reg && seq_mode_reg
                          && (step_cnt_reg >= STEP_CNT_W'(step_len_reg));
    assign step_cnt_chk = step_adv ? '0 : step_cnt_reg;
    assign parity_eff   = frame_start_reg ? 1'b0 : parity_reg;

    assign bright_idx   = LED_IDX_W'({cmd.chan, led_reg});
    assign count_scaled = PROD_W'({period_count_reg, 8'd0});

    always_comb
    begin
        period_count_next = period_count_reg + 1'b1;
        if (period_count_next == pwm_period_reg)
            period_count_next = '0;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_period_reg <= PERIOD_RESET;
            seq_mode_reg   <= 1'b1;
            hw_mode_reg    <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_PWM_PERIOD: pwm_period_reg <= cfg.data;
                REG_SEQ_MODE:   seq_mode_reg   <= cfg.data[0];
                REG_HW_PWM:     hw_mode_reg    <= cfg.data[0];
                default:        ;
            endcase
        end
    end

    // sample capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            frame_start_reg <= sample.frame_start;
            step_len_reg    <= sample.step_len_samples;
            master_reg      <= sample.master_level;
            for (int i = 0; i < LEVEL_INPUTS; i++)
                level_reg[i] <= level_in[i];
        end
    end

    // sequencer, parity, brightness latches, period counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_count_reg <= '0;
            parity_reg       <= 1'b0;
            step_index_reg   <= '0;
            step_cnt_reg     <= '0;
            for (int i = 0; i < NUM_LEDS; i++)
                bright_reg[i] <= '0;
        end
        else
        begin
            if (cmd.step_en)
            begin
                parity_reg <= !parity_eff;
                if (step_adv)
                    step_index_reg <= step_index_reg + 1'b1;
                if (seq_mode_reg && (step_cnt_chk != STEP_CNT_MAX))
                    step_cnt_reg <= step_cnt_chk + 1'b1;
                else
                    step_cnt_reg <= step_cnt_chk;
            end
            if (cmd.latch_en && frame_start_reg)
            begin
                for (int i = 0; i < NUM_LEDS; i++)
                begin
                    if (seq_mode_reg)
                    begin
                        case (pattern_code({1'b0, step_index_reg}, 5'(i), 5'(NUM_LEDS)))
                            PAT_FULL:  bright_reg[i] <= master_reg;
                            PAT_FIFTH: bright_reg[i] <= fifth_val;
                            default:   bright_reg[i] <= '0;
                        endcase
                    end
                    else if (i < LEVEL_INPUTS)
                        bright_reg[i] <= level_reg[i];
                    else
                        bright_reg[i] <= FULL_Q8;
                end
            end
            if (cmd.finish)
                period_count_reg <= period_count_next;
        end
    end

    // per-item work registers
    always_ff @(posedge clk)
    begin
        if (cmd.step_en)
        begin
            soft_reg <= hw_mode_reg ? 1'b0 : parity_eff;
            led_reg  <= hw_mode_reg ? period_count_reg[0] : period_count_reg[1];
            mask_reg <= '0;
        end
        if (cmd.mul_en)
            product_reg <= PROD_W'(bright_reg[bright_idx]) * PROD_W'(pwm_period_reg);
        if (cmd.cmp_en)
            mask_reg[cmd.chan] <= count_scaled < product_reg;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_soft_reg <= soft_reg;
            out_mask_reg <= mask_reg;
            out_led_reg  <= led_reg;
            out_step_reg <= step_index_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.soft_pwm_out   = out_soft_reg;
    assign result.pin_drive_mask = out_mask_reg;
    assign result.pin_level      = out_led_reg;
    assign result.current_step   = out_step_reg;

endmodule

/* src/blp_controller.sv */
// Controller: sequences one tick through step update, latch and per-channel multiply/compare.
module blp_controller #(
    parameter int NUM_CHANNELS = blp_pkg::NUM_CHANNELS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  blp_pkg::blp_status_t status,
    output blp_pkg::blp_cmd_t    cmd
);
    import blp_pkg::*;

    localparam int SERVED = (NUM_CHANNELS < MASK_W) ? NUM_CHANNELS : MASK_W;
    localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(SERVED - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_STEP  = 3'd1;
    localparam logic [2:0] S_LATCH = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [CHAN_W-1:0] chan_reg;
    logic [CHAN_W-1:0] chan_next;

    always_comb
    begin
        state_next   = state_reg;
        chan_next    = chan_reg;
        cmd          = '0;
        cmd.chan     = chan_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (status.in_valid)
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd.step_en = 1'b1;
                state_next  = S_LATCH;
            end
            S_LATCH:
            begin
                cmd.latch_en = 1'b1;
                chan_next    = '0;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp_en = 1'b1;
                if (chan_reg == LAST_CHAN)
                    state_next = S_DONE;
                else
                begin
                    chan_next  = chan_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            chan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
        end
    end

endmodule

/* src/blp_checker.sv */
// Checker: port-level assertions on the dimmer, bound to the top level.
module blp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_valid,
    input logic       s_ready,
    input logic       r_valid,
    input logic       r_ready,
    input logic       r_soft,
    input logic [3:0] r_mask,
    input logic       r_led,
    input logic [3:0] r_step
);
    logic s_xfer;
    assign s_xfer = s_valid && s_ready;

    // one tick at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer |=> !s_ready)
        else $error("sample taken while a tick is in progress");

    // a result never appears the cycle after a sample transfer
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer |=> !$rose(r_valid))
        else $error("result appeared too early");

    // a new result is only loaded at the end of a tick's work
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(r_valid) |-> $past(!s_ready))
        else $error("result loaded while idle");

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid && $stable(r_soft) && $stable(r_mask)
                                && $stable(r_led) && $stable(r_step))
        else $error("stalled result changed");

endmodule

bind bicolor_led_tristate_pwm blp_checker u_blp_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .s_valid(sample.valid),
    .s_ready(sample.ready),
    .r_valid(result.valid),
    .r_ready(result.ready),
    .r_soft (result.soft_pwm_out),
    .r_mask (result.pin_drive_mask),
    .r_led  (result.pin_level),
    .r_step (result.current_step)
);

/* test/bicolor_led_tristate_pwm_test.sv */
// Testbench for the bicolor LED tri-state PWM dimmer: predictor, scoreboard and drivers.
`timescale 1ns / 1ps

import blp_pkg::*;

// One sample tick as offered on the sample channel
typedef struct packed {
    logic                                 frame_start;
    logic [STEP_LEN_W-1:0]                step_len;
    logic [LEVEL_W-1:0]                   master;
    logic [LEVEL_INPUTS-1:0][LEVEL_W-1:0] level;
} tick_t;

// Pin state produced for one tick
typedef struct packed {
    logic              soft_pwm;
    logic [MASK_W-1:0] mask;
    logic              served_led;
    logic [STEP_W-1:0] step;
} pins_t;

class led_pwm_scoreboard;
    localparam int LEDS = 2 * NUM_CHANNELS_DEF;

    // register mirror
    logic [PERIOD_W-1:0]   pwm_period;
    logic                  seq_mode;
    logic                  hw_mode;

    // dimmer state
    logic [PERIOD_W-1:0]   period_count;
    logic                  parity;
    logic [STEP_W-1:0]     step_index;
    logic [STEP_CNT_W-1:0] step_count;
    logic [LEVEL_W-1:0]    brightness [LEDS];

    pins_t pins_due[$];
    int    mismatches;

    function new();
        pwm_period   = PERIOD_RESET;
        seq_mode     = 1'b1;
        hw_mode      = 1'b0;
        period_count = '0;
        parity       = 1'b0;
        step_index   = '0;
        step_count   = '0;
        foreach (brightness[i])
            brightness[i] = '0;
        mismatches   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_PWM_PERIOD: pwm_period = data[PERIOD_W-1:0];
            REG_SEQ_MODE:   seq_mode   = data[0];
            REG_HW_PWM:     hw_mode    = data[0];
            default: ;
        endcase
    endfunction

    // Q1.8 level of LED l in pattern step s: lone LEDs, then pairs full/fifth and swapped
    function int unsigned step_pattern(int unsigned s, int unsigned l);
        int unsigned t;
        if (s < LEDS)
            return (l == s) ? FULL_Q8 : 0;
        t = s - LEDS;
        if (t >= LEDS)
            return 0;
        if (l == (t & ~1))
            return (t % 2 == 0) ? FULL_Q8 : FIFTH_Q8;
        if (l == (t & ~1) + 1)
            return (t % 2 == 0) ? FIFTH_Q8 : FULL_Q8;
        return 0;
    endfunction

    function void note_tick(tick_t t);
        pins_t       exp;
        int unsigned b;
        int unsigned lvl;
        if (t.frame_start)
        begin
            parity = 1'b0;
            if (seq_mode)
            begin
                if (step_count >= t.step_len)
                begin
                    step_count = '0;
                    step_index = step_index + 1'b1;
                end
                for (int i = 0; i < LEDS; i++)
                begin
                    lvl = (step_pattern(step_index, i) * t.master + 128) >> 8;
                    brightness[i] = lvl[LEVEL_W-1:0];
                end
            end
            else
            begin
                for (int i = 0; i < LEDS; i++)
                    brightness[i] = (i < LEVEL_INPUTS) ? t.level[i] : FULL_Q8;
            end
        end
        if (seq_mode && step_count != STEP_CNT_MAX)
            step_count = step_count + 1'b1;

        exp.soft_pwm   = hw_mode ? 1'b0 : parity;
        parity         = ~parity;
        exp.served_led = hw_mode ? period_count[0] : period_count[1];
        exp.mask       = '0;
        for (int c = 0; c < NUM_CHANNELS_DEF; c++)
        begin
            b = brightness[2 * c + exp.served_led];
            if (c < MASK_W && (int'(period_count) * 256) < (b * int'(pwm_period)))
                exp.mask[c] = 1'b1;
        end
        period_count = period_count + 1'b1;
        if (period_count == pwm_period)
            period_count = '0;
        exp.step = step_index;
        pins_due.push_back(exp);
    endfunction

    task report(string msg);
        mismatches++;
        if (mismatches <= 100)
            $display("MISMATCH %0d at %0t: %s", mismatches, $realtime, msg);
    endtask

    task check_pins(pins_t got);
        pins_t exp;
        if (pins_due.size() == 0)
        begin
            report($sformatf("unexpected result mask=%h level=%b", got.mask, got.served_led));
            return;
        end
        exp = pins_due.pop_front();
        if (got.soft_pwm !== exp.soft_pwm)
            report($sformatf("soft_pwm_out %b, want %b", got.soft_pwm, exp.soft_pwm));
        if (got.mask !== exp.mask)
            report($sformatf("pin_drive_mask %h, want %h", got.mask, exp.mask));
        if (got.served_led !== exp.served_led)
            report($sformatf("pin_level %b, want %b", got.served_led, exp.served_led));
        if (got.step !== exp.step)
            report($sformatf("current_step %0d, want %0d", got.step, exp.step));
    endtask
endclass

module bicolor_led_tristate_pwm_test;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 135;
    localparam int HOLD_AT      = 320;   // ticks accepted before the long output hold
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 40;    // margin at the end of the run

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    blp_sample_if sample_ch ();
    blp_result_if result_ch ();
    blp_cfg_if    cfg_ch ();

    bicolor_led_tristate_pwm uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    led_pwm_scoreboard sb;

    int n_ticks    = 0;
    int n_results  = 0;
    int n_settings = 0;
    int cycles     = 0;
    bit quiet      = 1'b0;   // no idling on either side while set
    bit hold_done  = 1'b0;

    always #2 clk = ~clk;

    // Watchdog: a hung handshake or a missing result ends the run here
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.pins_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Monitor: every transfer is seen at the rising edge; an input transfer
    // is predicted on the spot, an output transfer is checked against the
    // oldest prediction.
    always @(posedge clk)
    begin : monitor
        tick_t t;
        pins_t p;
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                t.frame_start = sample_ch.frame_start;
                t.step_len    = sample_ch.step_len_samples;
                t.master      = sample_ch.master_level;
                t.level[0]    = sample_ch.level_0;
                t.level[1]    = sample_ch.level_1;
                t.level[2]    = sample_ch.level_2;
                t.level[3]    = sample_ch.level_3;
                t.level[4]    = sample_ch.level_4;
                t.level[5]    = sample_ch.level_5;
                t.level[6]    = sample_ch.level_6;
                t.level[7]    = sample_ch.level_7;
                sb.note_tick(t);
                n_ticks++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                p.soft_pwm   = result_ch.soft_pwm_out;
                p.mask       = result_ch.pin_drive_mask;
                p.served_led = result_ch.pin_level;
                p.step       = result_ch.current_step;
                sb.check_pins(p);
                n_results++;
            end
        end
    end

    // Idle stretch length: mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int sender_gap();
        if (quiet || $urandom_range(0, 99) < 55)
            return 0;
        return idle_len();
    endfunction

    // Receiver: random stalls, plus one long hold once the run is well under way.
    // The hold is timed here while the sender keeps offering ticks, so the
    // result register fills and the block has to stall its input.
    initial
    begin : receiver
        int stall;
        stall = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && n_ticks >= HOLD_AT)
            begin
                result_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (quiet)
                result_ch.ready = 1'b1;
            else if (stall > 0)
            begin
                result_ch.ready = 1'b0;
                stall--;
            end
            else if ($urandom_range(0, 99) < 60)
                result_ch.ready = 1'b1;
            else
            begin
                result_ch.ready = 1'b0;
                stall = idle_len() - 1;
            end
        end
    end

    // Offer one tick after a random gap and hold it until the transfer.
    // valid stays high across back-to-back ticks.
    task automatic drive_tick(tick_t t);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            sample_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        sample_ch.frame_start      = t.frame_start;
        sample_ch.step_len_samples = t.step_len;
        sample_ch.master_level     = t.master;
        sample_ch.level_0          = t.level[0];
        sample_ch.level_1          = t.level[1];
        sample_ch.level_2          = t.level[2];
        sample_ch.level_3          = t.level[3];
        sample_ch.level_4          = t.level[4];
        sample_ch.level_5          = t.level[5];
        sample_ch.level_6          = t.level[6];
        sample_ch.level_7          = t.level[7];
        sample_ch.valid            = 1'b1;
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    // Every tick gives a result, so an empty queue with valid low means idle
    task automatic wait_idle();
        @(negedge clk);
        sample_ch.valid = 1'b0;
        while (sb.pins_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        cfg_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic apply_setting(logic [PERIOD_W-1:0] period, bit seq, bit hw);
        wait_idle();
        write_reg(REG_PWM_PERIOD, period);
        write_reg(REG_SEQ_MODE, {{(CFG_DATA_W-1){1'b0}}, seq});
        write_reg(REG_HW_PWM, {{(CFG_DATA_W-1){1'b0}}, hw});
        n_settings++;
    endtask

    // Levels lean on zero, full and the top code
    function automatic logic [LEVEL_W-1:0] pick_level();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        if (r < 30)
            return FULL_Q8;
        if (r < 40)
            return '1;
        return LEVEL_W'($urandom_range(0, 511));
    endfunction

    // Short step lengths keep the pattern moving; the rest spans the field
    function automatic tick_t make_tick(bit fs);
        tick_t t;
        int    r;
        t.frame_start = fs;
        r = $urandom_range(0, 99);
        if (r < 70)
            t.step_len = STEP_LEN_W'($urandom_range(0, 12));
        else if (r < 85)
            t.step_len = STEP_LEN_W'($urandom_range(0, 300));
        else
            t.step_len = STEP_LEN_W'($urandom_range(0, 65535));
        t.master = pick_level();
        for (int i = 0; i < LEVEL_INPUTS; i++)
            t.level[i] = pick_level();
        return t;
    endfunction

    // Mostly well-formed blocks (frame start, then plain ticks), some stray ticks
    task automatic random_phase(int n);
        int sent;
        int len;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                  : $urandom_range(1, 16);
                for (int j = 0; j < len && sent < n; j++)
                begin
                    drive_tick(make_tick(j == 0));
                    sent++;
                end
            end
            else
            begin
                drive_tick(make_tick(1'($urandom_range(0, 1))));
                sent++;
            end
        end
    endtask

    initial
    begin : main
        tick_t               t;
        logic [PERIOD_W-1:0] period;

        sb = new();
        sample_ch.valid            = 1'b0;
        sample_ch.frame_start      = 1'b0;
        sample_ch.step_len_samples = '0;
        sample_ch.master_level     = '0;
        sample_ch.level_0          = '0;
        sample_ch.level_1          = '0;
        sample_ch.level_2          = '0;
        sample_ch.level_3          = '0;
        sample_ch.level_4          = '0;
        sample_ch.level_5          = '0;
        sample_ch.level_6          = '0;
        sample_ch.level_7          = '0;
        cfg_ch.valid               = 1'b0;
        cfg_ch.index               = REG_PWM_PERIOD;
        cfg_ch.data                = '0;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed, reset settings (pattern mode, soft PWM, period 176).
        // Before any frame start every LED is dark whatever the inputs say.
        repeat (3)
        begin
            t = make_tick(1'b0);
            t.master = '1;
            drive_tick(t);
        end
        // zero step length: advance at once; longest step length: hold
        t = make_tick(1'b1);
        t.step_len = '0;
        t.master   = '1;
        drive_tick(t);
        t = make_tick(1'b1);
        t.step_len = '1;
        t.master   = '0;
        drive_tick(t);
        t = make_tick(1'b1);
        t.step_len = '0;
        t.master   = FULL_Q8;
        drive_tick(t);
        // walk the pattern through the pair steps up to the last step
        for (int k = 0; k < 13; k++)
        begin
            t = make_tick(1'b1);
            t.step_len = '0;
            t.master   = (k % 3 == 0) ? 9'd1 : 9'd511;
            drive_tick(t);
        end

        // Direct levels, hardware PWM, longest period
        apply_setting(12'd4095, 1'b0, 1'b1);
        t = make_tick(1'b1);
        t.level = '1;
        drive_tick(t);
        t = make_tick(1'b1);
        t.level = '0;
        drive_tick(t);
        t = make_tick(1'b1);
        for (int i = 0; i < LEVEL_INPUTS; i++)
            t.level[i] = FULL_Q8;
        drive_tick(t);
        t = make_tick(1'b1);
        for (int i = 0; i < LEVEL_INPUTS; i++)
            t.level[i] = (i % 2 == 0) ? 9'h155 : 9'h0aa;
        drive_tick(t);
        t = make_tick(1'b0);
        t.level = '0;
        drive_tick(t);

        // Random phases; each covers a different period and mode pair.
        // Moving from a long period to a short one leaves the counter above
        // the new period, so it runs on to the 12-bit wrap.
        for (int k = 0; k < NUM_PHASES; k++)
        begin
            case (k)
                0:       period = 12'd1;
                1:       period = 12'd4095;
                2:       period = 12'd2;
                3:       period = 12'd3;
                4:       period = PERIOD_RESET;
                5:       period = PERIOD_W'($urandom_range(1, 4095));
                6:       period = PERIOD_W'($urandom_range(4, 64));
                default: period = PERIOD_W'($urandom_range(100, 500));
            endcase
            apply_setting(period, 1'(k % 2), 1'((k / 2) % 2));
            quiet = (k == 4);
            random_phase(PHASE_ITEMS);
        end
        quiet = 1'b0;

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d ticks and %0d results over %0d register settings",
                 n_ticks, n_results, n_settings);
        $display("pattern and direct modes, soft and hardware PWM, periods 1 to 4095");
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches", sb.mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
